// File: sv/duty_triangle_wave_generator_unit_defines.svh
// Assertion macros shared by the duty triangle wave generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DUTY_TRIANGLE_WAVE_GENERATOR_UNIT_DEFINES_SVH
`define DUTY_TRIANGLE_WAVE_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DTW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true outside reset
`define DTW_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define DTW_ASSERT(label, clk, rst_n, prop, msg)

`define DTW_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/dtw_pkg.sv
// Types, constants and register indexes of the duty triangle wave generator.
// Depends on nothing; imported by every module of the block.
package dtw_pkg;

    // register port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'b1;

    localparam int DUTY_W   = 7;
    localparam int TBL_W    = 8;
    localparam logic [DUTY_W-1:0] DUTY_RESET  = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_FULL   = 7'd100;
    localparam logic [TBL_W-1:0]  LENGTH_RESET = 8'd128;

    localparam int DEFAULT_MAX_LENGTH = 128;

    // lengths and quotients sized to hold values up to 256
    localparam int LEN_W   = 9;
    localparam int QUO_W   = 9;
    localparam int REM_W   = 8;
    localparam int WHOLE_W = 9;

    localparam int SAMPLE_W = 8;
    localparam int INDEX_W  = 7;

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 32768
    localparam logic [31:0] DIV100_MUL   = 32'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic               ready;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   rise;
        logic [LEN_W-1:0]   fall;
        logic [QUO_W-1:0]   rise_q;
        logic [REM_W-1:0]   rise_r;
        logic [QUO_W-1:0]   fall_q;
        logic [REM_W-1:0]   fall_r;
    } dtw_phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  sample_index;
        logic                period_end;
    } dtw_item_t;

endpackage

// File: sv/dtw_setup.sv
// Configuration registers and phase setup: clamps, rise/fall lengths and 256/len.
// Depends on dtw_pkg and the shared assertion macros.
`include "duty_triangle_wave_generator_unit_defines.svh"

module dtw_setup
    import dtw_pkg::*;
#(
    parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output dtw_phase_t            phase
);

    typedef enum logic [4:0] {
        ST_CALC  = 5'b00001,
        ST_SCALE = 5'b00010,
        ST_FIX   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_RUN   = 5'b10000
    } setup_state_t;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
    localparam logic [3:0]       DIV_LAST = 4'd8;

    setup_state_t state_reg, state_next;

    logic [DUTY_W-1:0] duty_reg;
    logic [TBL_W-1:0]  length_reg;
    logic              cfg_hit;

    logic [LEN_W-1:0]  n_eff;
    logic [DUTY_W-1:0] d_eff;
    logic [LEN_W-1:0]  n_reg;
    logic [15:0]       rise_x_reg, fall_x_reg;
    logic [LEN_W-1:0]  rise_reg, fall_reg;
    logic [LEN_W:0]    len_sum;
    logic [QUO_W-1:0]  rise_q_reg, fall_q_reg;
    logic [REM_W-1:0]  rise_r_reg, fall_r_reg;
    logic [3:0]        cnt_reg;
    logic              div_bit;
    logic [QUO_W-1:0]  rise_step, fall_step;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                                 input logic b,
                                                 input logic [LEN_W-1:0] d);
        logic [LEN_W-1:0] t;
        t = {r, b};
        if (t >= d) begin
            div_step = {1'b1, REM_W'(t - d)};
        end else begin
            div_step = {1'b0, REM_W'(t)};
        end
    endfunction

    always_comb begin
        cfg_hit = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_DUTY:   cfg_hit = 1'b1;
                REG_LENGTH: cfg_hit = 1'b1;
                default:    cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg   <= DUTY_RESET;
            length_reg <= LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DUTY:   duty_reg   <= cfg_wdata[DUTY_W-1:0];
                REG_LENGTH: length_reg <= cfg_wdata[TBL_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        n_eff = LEN_W'(length_reg);
        if (n_eff < LEN_MIN) begin
            n_eff = LEN_MIN;
        end else if (n_eff > LEN_MAX) begin
            n_eff = LEN_MAX;
        end
        d_eff = (duty_reg > DUTY_FULL) ? DUTY_FULL : duty_reg;
    end

    assign len_sum   = (LEN_W + 1)'(rise_reg) + (LEN_W + 1)'(fall_reg);
    // dividend is 256: only its top bit is set
    assign div_bit   = (cnt_reg == 4'd0);
    assign rise_step = div_step(rise_r_reg, div_bit, rise_reg);
    assign fall_step = div_step(fall_r_reg, div_bit, fall_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CALC:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_FIX;
            ST_FIX:   state_next = ST_DIV;
            ST_DIV:   state_next = (cnt_reg == DIV_LAST) ? ST_RUN : ST_DIV;
            ST_RUN:   state_next = ST_RUN;
            default:  state_next = ST_CALC;
        endcase
        if (cfg_hit) begin
            state_next = ST_CALC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CALC;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CALC: begin
                n_reg      <= n_eff;
                rise_x_reg <= 16'(n_eff) * 16'(d_eff) + 16'd50;
                fall_x_reg <= 16'(n_eff) * 16'(DUTY_FULL - d_eff) + 16'd50;
            end
            ST_SCALE: begin
                rise_reg <= LEN_W'((32'(rise_x_reg) * DIV100_MUL) >> DIV100_SHIFT);
                fall_reg <= LEN_W'((32'(fall_x_reg) * DIV100_MUL) >> DIV100_SHIFT);
            end
            ST_FIX: begin
                if (len_sum < (LEN_W + 1)'(n_reg)) begin
                    rise_reg <= rise_reg + LEN_W'(1);
                end
                rise_q_reg <= '0;
                fall_q_reg <= '0;
                rise_r_reg <= '0;
                fall_r_reg <= '0;
                cnt_reg    <= '0;
            end
            ST_DIV: begin
                rise_q_reg <= {rise_q_reg[QUO_W-2:0], rise_step[REM_W]};
                fall_q_reg <= {fall_q_reg[QUO_W-2:0], fall_step[REM_W]};
                rise_r_reg <= rise_step[REM_W-1:0];
                fall_r_reg <= fall_step[REM_W-1:0];
                cnt_reg    <= cnt_reg + 4'd1;
            end
            default: ;
        endcase
    end

    assign phase.ready  = (state_reg == ST_RUN);
    assign phase.length = n_reg;
    assign phase.rise   = rise_reg;
    assign phase.fall   = fall_reg;
    assign phase.rise_q = rise_q_reg;
    assign phase.rise_r = rise_r_reg;
    assign phase.fall_q = fall_q_reg;
    assign phase.fall_r = fall_r_reg;

    `DTW_ASSERT(a_cfg_stalls, aclk, aresetn, cfg_hit |=> !phase.ready, "config write did not stall")
    `DTW_ASSERT(a_len_cover, aclk, aresetn, phase.ready |-> (len_sum >= (LEN_W + 1)'(n_reg)), "phases short of period")
    `DTW_ASSERT(a_rise_rem, aclk, aresetn, (phase.ready && (rise_reg != '0)) |-> (LEN_W'(rise_r_reg) < rise_reg), "rise remainder out of range")
    `DTW_ASSERT(a_fall_rem, aclk, aresetn, (phase.ready && (fall_reg != '0)) |-> (LEN_W'(fall_r_reg) < fall_reg), "fall remainder out of range")

endmodule

// File: sv/dtw_step.sv
// Per-sample datapath: position and exact level tracking, sample formation.
// Depends on dtw_pkg; fed by dtw_setup, drives dtw_out_buf.
module dtw_step
    import dtw_pkg::*;
#(
    parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dtw_phase_t phase,
    input  logic       accept,
    input  logic       restart,
    output dtw_item_t  item
);

    localparam int POS_W = $clog2(MAX_LENGTH);

    logic [POS_W-1:0]   position_reg, position_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    logic [POS_W-1:0]   pos_cur;
    logic [WHOLE_W-1:0] whole_cur;
    logic [REM_W-1:0]   rem_cur;
    logic               in_rise;
    logic [WHOLE_W:0]   up;
    logic [POS_W:0]     pos_inc;
    logic               wrap;
    logic [LEN_W-1:0]   plen;
    logic [QUO_W-1:0]   pq;
    logic [REM_W-1:0]   pr;
    logic [REM_W:0]     rsum;
    logic               carry;

    always_comb begin
        pos_cur   = restart ? '0 : position_reg;
        whole_cur = restart ? '0 : whole_reg;
        rem_cur   = restart ? '0 : rem_reg;

        in_rise = LEN_W'(pos_cur) < phase.rise;
        plen    = in_rise ? phase.rise   : phase.fall;
        pq      = in_rise ? phase.rise_q : phase.fall_q;
        pr      = in_rise ? phase.rise_r : phase.fall_r;

        // fall level is 255 - ceil, floored at zero
        up = (WHOLE_W + 1)'(whole_cur) + (WHOLE_W + 1)'(rem_cur != '0);
        if (in_rise) begin
            item.sample = (whole_cur > WHOLE_W'(255)) ? 8'd255 : whole_cur[SAMPLE_W-1:0];
        end else begin
            item.sample = (up > (WHOLE_W + 1)'(255)) ? 8'd0
                                                     : SAMPLE_W'(10'd255 - 10'(up));
        end
        item.sample_index = INDEX_W'(pos_cur);

        pos_inc = (POS_W + 1)'(pos_cur) + (POS_W + 1)'(1);
        wrap    = LEN_W'(pos_inc) >= phase.length;
        item.period_end = wrap;

        // level += 256/plen, remainder kept below plen with one correction
        rsum  = (REM_W + 1)'(rem_cur) + (REM_W + 1)'(pr);
        carry = LEN_W'(rsum) >= plen;

        position_next = POS_W'(pos_inc);
        whole_next    = whole_cur;
        rem_next      = rem_cur;
        if (wrap) begin
            position_next = '0;
            whole_next    = '0;
            rem_next      = '0;
        end else if (LEN_W'(pos_inc) == phase.rise) begin
            whole_next = '0;
            rem_next   = '0;
        end else if (plen != '0) begin
            if (carry) begin
                whole_next = whole_cur + WHOLE_W'(pq) + WHOLE_W'(1);
                rem_next   = REM_W'(LEN_W'(rsum) - plen);
            end else begin
                whole_next = whole_cur + WHOLE_W'(pq);
                rem_next   = rsum[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || !phase.ready) begin
            position_reg <= '0;
            whole_reg    <= '0;
            rem_reg      <= '0;
        end else if (accept) begin
            position_reg <= position_next;
            whole_reg    <= whole_next;
            rem_reg      <= rem_next;
        end
    end

endmodule

// File: sv/dtw_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on dtw_pkg and the shared assertion macros.
`include "duty_triangle_wave_generator_unit_defines.svh"

module dtw_out_buf
    import dtw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  dtw_item_t push_item,
    output logic      room,
    output logic      m_valid,
    input  logic      m_ready,
    output dtw_item_t out_item
);

    logic      out_vld_reg, out_vld_next;
    logic      skid_vld_reg, skid_vld_next;
    dtw_item_t out_item_reg, out_item_next;
    dtw_item_t skid_item_reg, skid_item_next;
    logic      pop;

    assign pop = out_vld_reg && m_ready;

    always_comb begin
        out_vld_next   = out_vld_reg;
        skid_vld_next  = skid_vld_reg;
        out_item_next  = out_item_reg;
        skid_item_next = skid_item_reg;
        if (pop) begin
            if (skid_vld_reg) begin
                out_item_next = skid_item_reg;
                skid_vld_next = 1'b0;
            end else begin
                out_vld_next  = push;
                out_item_next = push_item;
            end
        end else if (push) begin
            if (!out_vld_reg) begin
                out_vld_next  = 1'b1;
                out_item_next = push_item;
            end else begin
                skid_vld_next  = 1'b1;
                skid_item_next = push_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign room     = !skid_vld_reg;
    assign m_valid  = out_vld_reg;
    assign out_item = out_item_reg;

    `DTW_ASSERT_NEVER(a_skid_alone, aclk, aresetn, skid_vld_reg && !out_vld_reg, "skid full with output empty")
    `DTW_ASSERT_NEVER(a_push_full, aclk, aresetn, push && skid_vld_reg, "request pushed into full buffer")
    `DTW_ASSERT(a_skid_fill, aclk, aresetn, (push && out_vld_reg && !pop) |=> skid_vld_reg, "stalled request lost")
    `DTW_ASSERT(a_drain, aclk, aresetn, (pop && !skid_vld_reg && !push) |=> !out_vld_reg, "result repeated")

endmodule

// File: sv/duty_triangle_wave_generator_unit.sv
// Top level of the duty triangle wave generator: setup, sample datapath, result buffer.
// Depends on dtw_pkg, dtw_setup, dtw_step and dtw_out_buf.
//
// Produces one 8-bit sample of an asymmetric triangle wave per request, one request
// per clock while setup is done and the buffer has room, with m_valid from a register.
// The level is tracked exactly as whole part plus remainder, so each sample costs
// one add and one compare. After reset and after every register write the block
// runs its setup (length clamps, rise/fall split by a reciprocal multiply, then a
// 9-step restoring division of 256 by each phase length) and holds s_ready low
// until it finishes; the next sample after that is index 0 of the new waveform.
// A two-entry output buffer keeps s_ready high while one result waits.
module duty_triangle_wave_generator_unit
    import dtw_pkg::*;
#(
    parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SAMPLE_W-1:0]   m_sample,
    output logic [INDEX_W-1:0]    m_sample_index,
    output logic                  m_period_end
);

    dtw_phase_t phase;
    dtw_item_t  step_item;
    dtw_item_t  out_item;
    logic       room;
    logic       accept;

    assign s_ready = phase.ready && room;
    assign accept  = s_valid && s_ready;

    dtw_setup #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .phase     (phase)
    );

    dtw_step #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .phase   (phase),
        .accept  (accept),
        .restart (s_restart),
        .item    (step_item)
    );

    dtw_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (step_item),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .out_item  (out_item)
    );

    assign m_sample       = out_item.sample;
    assign m_sample_index = out_item.sample_index;
    assign m_period_end   = out_item.period_end;

endmodule

// File: dv/dtw_wave_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the duty triangle wave generator: tracks register writes, predicts
// every sample from accepted requests and compares accepted results in order.
// Depends on dtw_pkg.
module dtw_wave_checker
    import dtw_pkg::*;
#(
    parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_restart,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [SAMPLE_W-1:0]   m_sample,
    input  logic [INDEX_W-1:0]    m_sample_index,
    input  logic                  m_period_end,
    output int                    fail_count,
    output int                    pending
);

    logic [DUTY_W-1:0]  duty_reg;
    logic [TBL_W-1:0]   length_reg;
    logic [LEN_W-1:0]   rise_len;
    logic [LEN_W-1:0]   fall_len;
    logic [LEN_W-1:0]   wave_pos;
    logic [WHOLE_W-1:0] level_int;
    logic [REM_W-1:0]   level_frac;

    dtw_item_t samples_due[$];
    int        errors = 0;

    function automatic int period_len(input logic [TBL_W-1:0] len);
        int n;
        n = int'(len);
        if (n < 2) n = 2;
        if (n > MAX_LENGTH) n = MAX_LENGTH;
        return n;
    endfunction

    // new lengths from the registers, and the waveform starts over at index 0
    task automatic reload_wave();
        int n;
        int d;
        int r;
        int f;
        n = period_len(length_reg);
        d = (duty_reg > DUTY_FULL) ? int'(DUTY_FULL) : int'(duty_reg);
        r = (n * d + 50) / 100;
        f = (n * (100 - d) + 50) / 100;
        if (r + f < n) r++;
        rise_len   = LEN_W'(r);
        fall_len   = LEN_W'(f);
        wave_pos   = '0;
        level_int  = '0;
        level_frac = '0;
    endtask

    task automatic step_wave(input logic restart, output dtw_item_t item);
        int n;
        int lvl;
        int up;
        int plen;
        int nxt;
        int acc;
        n = period_len(length_reg);
        if (restart) begin
            wave_pos   = '0;
            level_int  = '0;
            level_frac = '0;
        end
        if (wave_pos < rise_len) begin
            lvl  = int'(level_int);
            plen = int'(rise_len);
        end else begin
            // falling side uses the ceiling of the level
            up   = int'(level_int) + ((level_frac != '0) ? 1 : 0);
            lvl  = (up > 255) ? 0 : 255 - up;
            plen = int'(fall_len);
        end
        if (lvl > 255) lvl = 255;
        item.sample       = lvl[SAMPLE_W-1:0];
        item.sample_index = wave_pos[INDEX_W-1:0];
        item.period_end   = 1'b0;
        nxt = int'(wave_pos) + 1;
        if (nxt >= n) begin
            item.period_end = 1'b1;
            wave_pos   = '0;
            level_int  = '0;
            level_frac = '0;
        end else if (nxt == int'(rise_len)) begin
            wave_pos   = LEN_W'(nxt);
            level_int  = '0;
            level_frac = '0;
        end else begin
            wave_pos = LEN_W'(nxt);
            acc = int'(level_frac) + 256;
            while (plen != 0 && acc >= plen) begin
                acc -= plen;
                level_int++;
            end
            level_frac = acc[REM_W-1:0];
        end
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        dtw_item_t want;
        if (!aresetn) begin
            duty_reg   = DUTY_RESET;
            length_reg = LENGTH_RESET;
            reload_wave();
            samples_due.delete();
        end else begin
            // results first: a request of this edge cannot have produced one yet
            if (m_valid && m_ready) begin
                if (samples_due.size() == 0) begin
                    errors++;
                    $display("%0t: sample with nothing pending expected none actual %0d",
                             $time, m_sample);
                end else begin
                    want = samples_due.pop_front();
                    note_mismatch("sample", int'(want.sample), int'(m_sample));
                    note_mismatch("sample_index", int'(want.sample_index),
                                  int'(m_sample_index));
                    note_mismatch("period_end", int'(want.period_end), int'(m_period_end));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DUTY: begin
                        duty_reg = cfg_wdata[DUTY_W-1:0];
                    end
                    REG_LENGTH: begin
                        length_reg = cfg_wdata[TBL_W-1:0];
                    end
                    default: begin
                    end
                endcase
                reload_wave();
            end
            if (s_valid && s_ready) begin
                step_wave(s_restart, want);
                samples_due.push_back(want);
            end
        end
        fail_count <= errors;
        pending    <= samples_due.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the duty triangle wave generator: clock, reset, register writes,
// request and result pacing, verdict. Depends on dtw_pkg, the block and dtw_wave_checker.
module tb;
    import dtw_pkg::*;

    localparam int IDLE_PCT     = 11;
    localparam int RESTART_PCT  = 3;
    localparam int WAVE_PHASES  = 13;
    localparam int PHASE_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 20;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_restart;
    logic                  m_valid;
    logic                  m_ready;
    logic [SAMPLE_W-1:0]   m_sample;
    logic [INDEX_W-1:0]    m_sample_index;
    logic                  m_period_end;
    logic                  steady;
    int                    fail_count;
    int                    pending;

    duty_triangle_wave_generator_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_sample_index (m_sample_index),
        .m_period_end   (m_period_end)
    );

    dtw_wave_checker u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_sample_index (m_sample_index),
        .m_period_end   (m_period_end),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // registers change only with nothing in flight and the setup pass done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0 || !s_ready);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input logic restart);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_wave(input int count, input int restart_pct);
        for (int i = 0; i < count; i++)
            send_sample($urandom_range(0, 99) < restart_pct);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] duty_data;
        logic [CFG_DATA_W-1:0] len_data;
        int                    pick;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_DUTY;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_restart = 1'b0;
        steady    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset waveform, restart on the first sample and again mid-rise
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        // shortest period, all falling then all rising
        write_reg(REG_DUTY, 8'd0);
        write_reg(REG_LENGTH, 8'd2);
        run_wave(3, 0);
        write_reg(REG_DUTY, 8'd100);
        run_wave(3, 0);
        // both halves round up past the period, last fall sample never shows
        write_reg(REG_DUTY, 8'd50);
        write_reg(REG_LENGTH, 8'd3);
        run_wave(4, 0);
        // duty above range, length below range
        write_reg(REG_DUTY, 8'hFF);
        write_reg(REG_LENGTH, 8'd1);
        run_wave(2, 0);
        write_reg(REG_LENGTH, 8'd0);
        send_sample(1'b1);
        send_sample(1'b1);
        // top data bit is dropped from the duty, length above range is clamped
        write_reg(REG_DUTY, 8'h80);
        write_reg(REG_LENGTH, 8'hFF);
        run_wave(4, 0);
        write_reg(REG_DUTY, 8'd33);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);

        for (int p = 0; p < WAVE_PHASES; p++) begin
            steady <= (p == 5 || p == 6);
            case (p)
                0: begin
                    duty_data = 8'd0;
                    len_data  = 8'd128;
                end
                1: begin
                    duty_data = 8'd100;
                    len_data  = 8'd128;
                end
                2: begin
                    duty_data = 8'h7F;
                    len_data  = 8'd255;
                end
                3: begin
                    duty_data = 8'd1;
                    len_data  = 8'd2;
                end
                default: begin
                    duty_data = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 100));
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        len_data = 8'($urandom_range(2, 40));
                    else if (pick < 9)
                        len_data = 8'($urandom_range(2, 128));
                    else
                        len_data = 8'($urandom_range(0, 255));
                end
            endcase
            pick = (p < 4) ? 0 : $urandom_range(0, 5);
            if (pick == 1) begin
                write_reg(REG_DUTY, duty_data);
            end else if (pick == 2) begin
                write_reg(REG_LENGTH, len_data);
            end else if (pick == 3) begin
                write_reg(REG_LENGTH, len_data);
                write_reg(REG_DUTY, duty_data);
            end else begin
                write_reg(REG_DUTY, duty_data);
                write_reg(REG_LENGTH, len_data);
            end
            run_wave(PHASE_ITEMS, RESTART_PCT);
        end

        steady <= 1'b0;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/dtw_pkg.sv
sv/dtw_setup.sv
sv/dtw_step.sv
sv/dtw_out_buf.sv
sv/duty_triangle_wave_generator_unit.sv
dv/dtw_wave_checker.sv
dv/tb.sv
